// ----- design/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// Set-associative cache lookup package
// Shared types and constants for the tag-only cache lookup block.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int unsigned MAX_ACCESS_BYTES = 64;

  localparam logic [2:0]  BLK_LOG2_RST = 3'd5;
  localparam logic [3:0]  SET_LOG2_RST = 4'd6;
  localparam logic [3:0]  WAYS_RST     = 4'd4;
  localparam logic [15:0] LFSR_SEED    = 16'hACE1;

  typedef enum logic [1:0] {
    REG_BLOCK_LOG2 = 2'd0,
    REG_SET_LOG2   = 2'd1,
    REG_WAYS       = 2'd2,
    REG_RANDOM     = 2'd3
  } reg_idx_e;

  typedef enum logic {
    FUNC_ACCESS = 1'b0,
    FUNC_FLUSH  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    OC_HIT  = 2'd0,
    OC_COMP = 2'd1,
    OC_CONF = 2'd2,
    OC_NONE = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_MOD,
    ST_UPD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        func;
    logic [31:0] address;
    logic [6:0]  access_bytes;
  } req_t;

  typedef struct packed {
    logic [31:0] block_address;
    outcome_e    outcome;
    logic [2:0]  way_used;
    logic [7:0]  cost_cycles;
    logic        last;
    logic [31:0] access_total;
    logic [31:0] hit_total;
    logic [31:0] compulsory_total;
    logic [31:0] conflict_total;
    logic [47:0] cycle_total;
  } rsp_t;

endpackage

// ----- design/sacl_store.sv -----
// ----------------------------------------------------------------------------
// Cache lookup store
// Per-set metadata memory (valid bits and replacement pointer) and tag memory,
// each with one port and registered read data.
// ----------------------------------------------------------------------------
module sacl_store #(
  parameter int SW = 8,
  parameter int WW = 3,
  parameter int MW = 8
) (
  input  logic               clk_i,
  input  logic               meta_re_i,
  input  logic               meta_we_i,
  input  logic [SW-1:0]      meta_addr_i,
  input  logic [MW+WW-1:0]   meta_wdata_i,
  output logic [MW+WW-1:0]   meta_rdata_o,
  input  logic               tag_re_i,
  input  logic               tag_we_i,
  input  logic [SW+WW-1:0]   tag_addr_i,
  input  logic [31:0]        tag_wdata_i,
  output logic [31:0]        tag_rdata_o
);

  logic [MW+WW-1:0] meta_mem [1<<SW];
  logic [31:0]      tag_mem  [1<<(SW+WW)];

  always_ff @(posedge clk_i) begin
    if (meta_we_i) begin
      meta_mem[meta_addr_i] <= meta_wdata_i;
    end
    if (meta_re_i) begin
      meta_rdata_o <= meta_mem[meta_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we_i) begin
      tag_mem[tag_addr_i] <= tag_wdata_i;
    end
    if (tag_re_i) begin
      tag_rdata_o <= tag_mem[tag_addr_i];
    end
  end

endmodule

// ----- design/set_assoc_cache_lookup.sv -----
// ----------------------------------------------------------------------------
// Set-associative cache lookup
// Tag-only cache model with round-robin or pseudo-random replacement.
// ----------------------------------------------------------------------------
// Each block of an access goes through a read, up to one tag compare per way through the
// single tag memory port, an update and the result. A random conflict victim adds
// a modulo step on the LFSR value before the update.
// One item is handled at a time; the next is taken in the cycle after the last result leaves.
// After reset and after a flush a clearing pass writes every set's metadata,
// one set per cycle, while no item is accepted.
module set_assoc_cache_lookup #(
  parameter int MAX_SETS_LOG2 = 8,
  parameter int MAX_WAYS      = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sacl_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sacl_pkg::rsp_t out_data_o
);
  import sacl_pkg::*;

  localparam int SW = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
  localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int MTW = MAX_WAYS + WW;

  logic [2:0]  blk_log2_q;
  logic [3:0]  set_log2_q;
  logic [3:0]  ways_q;
  logic        rnd_q;

  state_e      state_q, state_d;
  logic [SW-1:0] clr_q;
  logic        flush_q;
  logic [31:0] bidx_q, lastb_q;
  logic [WW-1:0] way_q, hway_q;
  logic        hit_q;
  logic [4:0]  rem_q;
  logic [3:0]  bit_q;
  logic [15:0] lfsr_q;
  logic [31:0] acc_q, hits_q, comp_q, conf_q;
  logic [47:0] cyc_q;
  rsp_t        rsp_q;

  logic        meta_re, meta_we, tag_re, tag_we;
  logic [SW-1:0] meta_addr;
  logic [MTW-1:0] meta_wdata, meta_rdata;
  logic [SW+WW-1:0] tag_addr;
  logic [31:0] tag_rdata;

  logic        cfg_wr;
  logic [3:0]  sl;
  logic [4:0]  ways_eff;
  logic [SW:0] set_mask_w;
  logic [SW-1:0] set_idx;
  logic [31:0] tag_cur;
  logic        last_blk;
  logic        match, scan_end;
  logic [MAX_WAYS-1:0] vld_row;
  logic [WW-1:0] ptr_row;
  logic        inv_any;
  logic [WW-1:0] inv_way;
  logic [15:0] lfsr_nx;
  logic [4:0]  rem_sh, rem_nx;
  logic [6:0]  size_sat;
  logic [32:0] end_addr;
  logic        in_skip;
  logic [7:0]  miss_cost;

  outcome_e    upd_oc;
  logic [WW-1:0] upd_way, upd_ptr;
  logic [7:0]  upd_cost;
  logic [31:0] acc_n, hits_n, comp_n, conf_n;
  logic [48:0] cyc_sum;
  logic [47:0] cyc_n;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_log2_q <= BLK_LOG2_RST;
      set_log2_q <= SET_LOG2_RST;
      ways_q     <= WAYS_RST;
      rnd_q      <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_BLOCK_LOG2: blk_log2_q <= pwdata[2:0];
        REG_SET_LOG2:   set_log2_q <= pwdata[3:0];
        REG_WAYS:       ways_q     <= pwdata[3:0];
        REG_RANDOM:     rnd_q      <= pwdata[0];
        default:        rnd_q      <= rnd_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_BLOCK_LOG2: prdata = {29'd0, blk_log2_q};
      REG_SET_LOG2:   prdata = {28'd0, set_log2_q};
      REG_WAYS:       prdata = {28'd0, ways_q};
      REG_RANDOM:     prdata = {31'd0, rnd_q};
      default:        prdata = '0;
    endcase
  end

  // Geometry derived from the registers.
  assign sl = (set_log2_q > 4'(MAX_SETS_LOG2)) ? 4'(MAX_SETS_LOG2) : set_log2_q;
  assign ways_eff = (ways_q == 4'd0) ? 5'd1 :
                    (({1'b0, ways_q} > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : {1'b0, ways_q});
  assign set_mask_w = ((SW+1)'(1) << sl) - (SW+1)'(1);
  assign set_idx    = bidx_q[SW-1:0] & set_mask_w[SW-1:0];
  assign tag_cur    = bidx_q >> sl;
  assign last_blk   = (bidx_q == lastb_q);
  assign miss_cost  = (blk_log2_q < 3'd2) ? 8'd4 : (8'd1 << blk_log2_q);

  assign size_sat = (in_data_i.access_bytes > 7'(MAX_ACCESS_BYTES)) ?
                    7'(MAX_ACCESS_BYTES) : in_data_i.access_bytes;
  assign end_addr = {1'b0, in_data_i.address} + 33'(size_sat) - 33'd1;
  assign in_skip  = (size_sat == 7'd0) || end_addr[32];

  assign vld_row = meta_rdata[MAX_WAYS-1:0];
  assign ptr_row = meta_rdata[MTW-1:MAX_WAYS];
  assign match   = vld_row[way_q] && (tag_rdata == tag_cur);
  assign scan_end = ({{(5-WW){1'b0}}, way_q} + 5'd1) >= ways_eff;

  always_comb begin
    inv_any = 1'b0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((5'(w) < ways_eff) && !vld_row[w]) begin
        inv_any = 1'b1;
        inv_way = WW'(w);
      end
    end
  end

  assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  assign rem_sh  = {rem_q[3:0], lfsr_q[bit_q]};
  assign rem_nx  = (rem_sh >= ways_eff) ? rem_sh - ways_eff : rem_sh;

  // Update of one block.
  always_comb begin
    upd_ptr = ptr_row;
    if (hit_q) begin
      upd_oc  = OC_HIT;
      upd_way = hway_q;
    end else if (inv_any) begin
      upd_oc  = OC_COMP;
      upd_way = inv_way;
    end else if (rnd_q) begin
      upd_oc  = OC_CONF;
      upd_way = rem_q[WW-1:0];
    end else begin
      upd_oc  = OC_CONF;
      upd_way = ({{(5-WW){1'b0}}, ptr_row} < ways_eff) ? ptr_row : '0;
      upd_ptr = (({{(5-WW){1'b0}}, upd_way} + 5'd1) == ways_eff) ? '0 : upd_way + WW'(1);
    end
    upd_cost = hit_q ? 8'd1 : miss_cost;
    acc_n  = (&acc_q) ? acc_q : acc_q + 32'd1;
    hits_n = (hit_q && !(&hits_q)) ? hits_q + 32'd1 : hits_q;
    comp_n = ((upd_oc == OC_COMP) && !(&comp_q)) ? comp_q + 32'd1 : comp_q;
    conf_n = ((upd_oc == OC_CONF) && !(&conf_q)) ? conf_q + 32'd1 : conf_q;
    cyc_sum = {1'b0, cyc_q} + 49'(upd_cost);
    cyc_n   = cyc_sum[48] ? '1 : cyc_sum[47:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (&clr_q) state_d = flush_q ? ST_OUT : ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.func == FUNC_FLUSH) state_d = ST_CLEAR;
          else if (in_skip) state_d = ST_OUT;
          else state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (match) state_d = ST_UPD;
        else if (scan_end) state_d = (inv_any || !rnd_q) ? ST_UPD : ST_MOD;
      end
      ST_MOD: if (bit_q == 4'd0) state_d = ST_UPD;
      ST_UPD: state_d = ST_OUT;
      ST_OUT: if (out_ready_i) state_d = rsp_q.last ? ST_IDLE : ST_READ;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    meta_re = 1'b0;
    meta_we = 1'b0;
    meta_addr = set_idx;
    meta_wdata = {upd_ptr, vld_row | (MAX_WAYS'(1) << upd_way)};
    tag_re = 1'b0;
    tag_we = 1'b0;
    tag_addr = {set_idx, way_q};
    unique case (state_q)
      ST_CLEAR: begin
        meta_we = 1'b1;
        meta_addr = clr_q;
        meta_wdata = '0;
      end
      ST_READ: begin
        meta_re = 1'b1;
        tag_re = 1'b1;
        tag_addr = {set_idx, {WW{1'b0}}};
      end
      ST_CMP: begin
        tag_re = 1'b1;
        tag_addr = {set_idx, way_q + WW'(1)};
      end
      ST_UPD: begin
        meta_we = !hit_q;
        tag_we = !hit_q;
        tag_addr = {set_idx, upd_way};
      end
      default: begin
        meta_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      flush_q <= 1'b0;
      lfsr_q  <= LFSR_SEED;
      acc_q   <= '0;
      hits_q  <= '0;
      comp_q  <= '0;
      conf_q  <= '0;
      cyc_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + SW'(1);
        ST_IDLE: begin
          if (in_valid_i) begin
            clr_q   <= '0;
            flush_q <= (in_data_i.func == FUNC_FLUSH);
          end
        end
        ST_CMP: begin
          if (!match && scan_end && !inv_any && rnd_q) lfsr_q <= lfsr_nx;
        end
        ST_UPD: begin
          acc_q  <= acc_n;
          hits_q <= hits_n;
          comp_q <= comp_n;
          conf_q <= conf_n;
          cyc_q  <= cyc_n;
        end
        default: clr_q <= clr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        bidx_q  <= in_data_i.address >> blk_log2_q;
        lastb_q <= end_addr[31:0] >> blk_log2_q;
        rsp_q   <= '{block_address: '0, outcome: OC_NONE, way_used: '0,
                     cost_cycles: '0, last: 1'b1, access_total: acc_q,
                     hit_total: hits_q, compulsory_total: comp_q,
                     conflict_total: conf_q, cycle_total: cyc_q};
      end
      ST_READ: begin
        way_q <= '0;
        hit_q <= 1'b0;
      end
      ST_CMP: begin
        if (match) begin
          hit_q  <= 1'b1;
          hway_q <= way_q;
        end else if (!scan_end) begin
          way_q <= way_q + WW'(1);
        end
        rem_q <= '0;
        bit_q <= 4'd15;
      end
      ST_MOD: begin
        rem_q <= rem_nx;
        bit_q <= bit_q - 4'd1;
      end
      ST_UPD: begin
        rsp_q <= '{block_address: bidx_q << blk_log2_q, outcome: upd_oc,
                   way_used: 3'(upd_way), cost_cycles: upd_cost, last: last_blk,
                   access_total: acc_n, hit_total: hits_n, compulsory_total: comp_n,
                   conflict_total: conf_n, cycle_total: cyc_n};
      end
      ST_OUT: begin
        if (out_ready_i && !rsp_q.last) bidx_q <= bidx_q + 32'd1;
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  assign out_data_o = rsp_q;

  sacl_store #(
    .SW(SW),
    .WW(WW),
    .MW(MAX_WAYS)
  ) u_store (
    .clk_i        (clk_i),
    .meta_re_i    (meta_re),
    .meta_we_i    (meta_we),
    .meta_addr_i  (meta_addr),
    .meta_wdata_i (meta_wdata),
    .meta_rdata_o (meta_rdata),
    .tag_re_i     (tag_re),
    .tag_we_i     (tag_we),
    .tag_addr_i   (tag_addr),
    .tag_wdata_i  (tag_cur),
    .tag_rdata_o  (tag_rdata)
  );

endmodule

// ----- design/sacl_checker.sv -----
// ----------------------------------------------------------------------------
// Cache lookup checker
// Port-level properties of the cache lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module sacl_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sacl_pkg::rsp_t out_data_o
);
  import sacl_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result item changed while stalled.");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input taken while a result item is pending.");

  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome == OC_NONE) |->
      out_data_o.last && (out_data_o.cost_cycles == 8'd0))
    else $error("Empty result item is malformed.");

  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome == OC_HIT) |-> out_data_o.cost_cycles == 8'd1)
    else $error("Hit with wrong cost.");

endmodule

bind set_assoc_cache_lookup sacl_checker u_sacl_checker (.*);

// ----- tb/set_assoc_cache_lookup_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the set-associative cache lookup
// Drives access and flush items through the valid/ready input, writes the
// registers over the APB port between phases and predicts every result with
// its own tag, valid and pointer state. The results are checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module set_assoc_cache_lookup_tb;
  import sacl_pkg::*;

  localparam int SETS_LOG2 = 8;
  localparam int WAYS_MAX  = 8;
  localparam int WDOG_MAX  = 4000;
  localparam int SETTLE    = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_data_o;

  set_assoc_cache_lookup #(
    .MAX_SETS_LOG2(SETS_LOG2),
    .MAX_WAYS     (WAYS_MAX)
  ) i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  always #10 clk_i = ~clk_i;

  // Model of the cache state and registers.
  logic [31:0] tag_mem [0:(1<<SETS_LOG2)*WAYS_MAX-1];
  bit          way_vld [0:(1<<SETS_LOG2)*WAYS_MAX-1];
  logic [2:0]  rr_ptr  [0:(1<<SETS_LOG2)-1];
  logic [15:0] lfsr_q;
  logic [31:0] acc_cnt, hit_cnt, comp_cnt, conf_cnt;
  logic [47:0] cyc_sum;
  logic [2:0]  cfg_blk;
  logic [3:0]  cfg_sets, cfg_ways;
  logic        cfg_rnd;

  rsp_t rsp_q[$];
  int   errors = 0;
  int   burst_left = 0;
  bit   accepted_out;

  function automatic logic [31:0] sat32(logic [31:0] x);
    return (x == '1) ? x : x + 1;
  endfunction

  function automatic void push_rsp(logic [31:0] ba, outcome_e oc, logic [2:0] w,
                                   logic [7:0] cost, logic lst);
    rsp_t r;
    r.block_address = ba;
    r.outcome = oc;
    r.way_used = w;
    r.cost_cycles = cost;
    r.last = lst;
    r.access_total = acc_cnt;
    r.hit_total = hit_cnt;
    r.compulsory_total = comp_cnt;
    r.conflict_total = conf_cnt;
    r.cycle_total = cyc_sum;
    rsp_q.push_back(r);
  endfunction

  function automatic void flush_model();
    foreach (way_vld[k]) way_vld[k] = 1'b0;
    foreach (rr_ptr[k]) rr_ptr[k] = '0;
  endfunction

  function automatic void predict_lookup(req_t r);
    logic [63:0] addr, len, first, lastb, bidx;
    logic [31:0] tag;
    logic [48:0] sum;
    int sl, ways, off, set, base, way, n, cost;
    bit hit, inv;
    outcome_e oc;
    if (r.func == FUNC_FLUSH) begin
      flush_model();
      push_rsp('0, OC_NONE, '0, '0, 1'b1);
      return;
    end
    off = cfg_blk;
    sl = (cfg_sets > SETS_LOG2) ? SETS_LOG2 : cfg_sets;
    ways = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS_MAX) ? WAYS_MAX : cfg_ways);
    addr = r.address;
    len = (r.access_bytes > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : r.access_bytes;
    if (len == 0 || addr + len - 1 > 64'hFFFF_FFFF) begin
      push_rsp('0, OC_NONE, '0, '0, 1'b1);
      return;
    end
    first = addr >> off;
    lastb = (addr + len - 1) >> off;
    n = int'(lastb - first) + 1;
    for (int i = 0; i < n; i++) begin
      bidx = first + i;
      set = int'(bidx & ((64'd1 << sl) - 1));
      tag = 32'(bidx >> sl);
      base = set * WAYS_MAX;
      hit = 1'b0;
      inv = 1'b0;
      way = 0;
      acc_cnt = sat32(acc_cnt);
      for (int w = 0; w < ways && !hit; w++) begin
        if (way_vld[base+w] && tag_mem[base+w] == tag) begin
          hit = 1'b1;
          way = w;
        end
      end
      if (hit) begin
        hit_cnt = sat32(hit_cnt);
        oc = OC_HIT;
        cost = 1;
      end else begin
        for (int w = 0; w < ways && !inv; w++) begin
          if (!way_vld[base+w]) begin
            inv = 1'b1;
            way = w;
          end
        end
        if (inv) begin
          comp_cnt = sat32(comp_cnt);
          oc = OC_COMP;
        end else begin
          conf_cnt = sat32(conf_cnt);
          oc = OC_CONF;
          if (cfg_rnd) begin
            lfsr_q = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
            way = lfsr_q % ways;
          end else begin
            way = (rr_ptr[set] < ways) ? rr_ptr[set] : 0;
            rr_ptr[set] = (way + 1 == ways) ? 3'd0 : 3'(way + 1);
          end
        end
        way_vld[base+way] = 1'b1;
        tag_mem[base+way] = tag;
        cost = (((1 << off) + 3) / 4) * 4;
      end
      sum = cyc_sum + cost;
      cyc_sum = sum[48] ? '1 : sum[47:0];
      push_rsp(32'(bidx << off), oc, 3'(way), 8'(cost), i == n - 1);
    end
  endfunction

  // Receiver: stall pattern steps through always ready, random, a fixed pattern and random holds.
  int rx_cyc = 0;
  int rx_hold = 0;
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      case ((rx_cyc / 64) % 4)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        2: out_ready_i <= (rx_cyc % 3 != 0);
        default: begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_hold <= $urandom_range(5, 20);
        end
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    rsp_t e;
    accepted_out = out_valid_o && out_ready_i;
    if (rst_ni && accepted_out) begin
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data_o);
        errors++;
      end else begin
        e = rsp_q.pop_front();
        if (out_data_o.block_address !== e.block_address)
          $display("%0t: block_address expected %h actual %h", $time,
                   e.block_address, out_data_o.block_address);
        if (out_data_o.outcome !== e.outcome)
          $display("%0t: outcome expected %0d actual %0d", $time, e.outcome,
                   out_data_o.outcome);
        if (out_data_o.way_used !== e.way_used)
          $display("%0t: way_used expected %0d actual %0d", $time, e.way_used,
                   out_data_o.way_used);
        if (out_data_o.cost_cycles !== e.cost_cycles)
          $display("%0t: cost_cycles expected %0d actual %0d", $time,
                   e.cost_cycles, out_data_o.cost_cycles);
        if (out_data_o.last !== e.last)
          $display("%0t: last expected %b actual %b", $time, e.last, out_data_o.last);
        if (out_data_o.access_total !== e.access_total)
          $display("%0t: access_total expected %0d actual %0d", $time,
                   e.access_total, out_data_o.access_total);
        if (out_data_o.hit_total !== e.hit_total)
          $display("%0t: hit_total expected %0d actual %0d", $time, e.hit_total,
                   out_data_o.hit_total);
        if (out_data_o.compulsory_total !== e.compulsory_total)
          $display("%0t: compulsory_total expected %0d actual %0d", $time,
                   e.compulsory_total, out_data_o.compulsory_total);
        if (out_data_o.conflict_total !== e.conflict_total)
          $display("%0t: conflict_total expected %0d actual %0d", $time,
                   e.conflict_total, out_data_o.conflict_total);
        if (out_data_o.cycle_total !== e.cycle_total)
          $display("%0t: cycle_total expected %0d actual %0d", $time,
                   e.cycle_total, out_data_o.cycle_total);
        if (out_data_o !== e) errors++;
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  int idle_cyc = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_MAX) begin
      $display("FAIL set_assoc_cache_lookup");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic send_item(logic f, logic [31:0] a, logic [6:0] n);
    req_t r;
    int gap;
    r.func = f;
    r.address = a;
    r.access_bytes = n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predict_lookup(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (rsp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BLOCK_LOG2: cfg_blk = val[2:0];
      REG_SET_LOG2:   cfg_sets = val[3:0];
      REG_WAYS:       cfg_ways = val[3:0];
      default:        cfg_rnd = val[0];
    endcase
  endtask

  task automatic set_config(int blk, int sets, int ways, int rnd);
    drain();
    write_reg(REG_BLOCK_LOG2, blk);
    write_reg(REG_SET_LOG2, sets);
    write_reg(REG_WAYS, ways);
    write_reg(REG_RANDOM, rnd);
  endtask

  task automatic send_random();
    logic [31:0] a;
    logic [6:0]  n;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      a = $urandom_range(0, 7) * (32'd1 << $urandom_range(6, 16)) + $urandom_range(0, 255);
    else if (pick < 92)
      a = $urandom;
    else
      a = 32'hFFFF_FFFF - $urandom_range(0, 100);
    n = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 64));
    send_item(($urandom_range(0, 29) == 0) ? FUNC_FLUSH : FUNC_ACCESS, a, n);
  endtask

  task automatic test_directed();
    send_item(FUNC_ACCESS, 32'h0000_0000, 7'd1);
    send_item(FUNC_ACCESS, 32'h0000_0010, 7'd4);
    send_item(FUNC_ACCESS, 32'h0000_001E, 7'd4);
    send_item(FUNC_ACCESS, 32'h0000_0101, 7'd64);
    send_item(FUNC_ACCESS, 32'h0000_0040, 7'd0);
    send_item(FUNC_ACCESS, 32'h0000_0200, 7'd127);
    send_item(FUNC_ACCESS, 32'hFFFF_FFF0, 7'd32);
    send_item(FUNC_ACCESS, 32'hFFFF_FFC0, 7'd64);
    send_item(FUNC_ACCESS, 32'hFFFF_FFFF, 7'd1);
    for (int k = 0; k < 7; k++) send_item(FUNC_ACCESS, k * 32'd2048 + 4, 7'd8);
    send_item(FUNC_ACCESS, 32'h0000_0000, 7'd1);
    send_item(FUNC_FLUSH, 32'hFFFF_FFFF, 7'd127);
    send_item(FUNC_ACCESS, 32'h0000_0000, 7'd1);
  endtask

  task automatic test_pointer_left_high();
    set_config(2, 0, 8, 0);
    for (int k = 0; k < 14; k++) send_item(FUNC_ACCESS, k * 32'd4, 7'd1);
    set_config(2, 0, 2, 0);
    for (int k = 20; k < 24; k++) send_item(FUNC_ACCESS, k * 32'd4, 7'd1);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(0, 0, 1, 0);
        1: set_config(7, 8, 8, 1);
        2: set_config(0, 15, 0, 1);
        3: set_config(7, 0, 15, 0);
        4: set_config(3, 2, 3, 1);
        default: set_config($urandom_range(0, 7), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 1));
      endcase
      for (int k = 0; k < 27; k++) send_random();
    end
  endtask

  initial begin
    flush_model();
    lfsr_q = LFSR_SEED;
    {acc_cnt, hit_cnt, comp_cnt, conf_cnt} = '0;
    cyc_sum = '0;
    cfg_blk = BLK_LOG2_RST;
    cfg_sets = SET_LOG2_RST;
    cfg_ways = WAYS_RST;
    cfg_rnd = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pointer_left_high();
    test_random_phases();
    drain();
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("PASS set_assoc_cache_lookup");
    end else begin
      $display("FAIL set_assoc_cache_lookup");
    end
    $finish;
  end

endmodule
